/* src/awd_pkg.sv */
// shared types and constants for the alpha weighted 2x2 downsampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package awd_pkg;

	localparam int ChanW     = 8;   // one color or alpha channel
	localparam int ProdW     = 16;  // channel times alpha
	localparam int SumW      = 18;  // sum of four products
	localparam int AlphaSumW = 10;  // sum of four alphas
	localparam int KeptW     = 3;   // count of kept pixels, 0..4
	localparam int Lanes     = 4;   // one lane per source pixel
	localparam int Colors    = 3;   // red, green, blue
	localparam int DivStages = 8;   // one quotient bit per stage

	localparam logic [ChanW-1:0] ThreshReset = 8'd100;

	// x / 3 as (x * 683) >> 11, exact for x below 2048
	localparam logic [AlphaSumW-1:0] Recip3      = 10'd683;
	localparam int                   Recip3Shift = 11;

	typedef struct packed {
		logic [31:0] pixel_top_left;
		logic [31:0] pixel_top_right;
		logic [31:0] pixel_bottom_left;
		logic [31:0] pixel_bottom_right;
	} pixel_block_t;

	typedef struct packed {
		logic [ChanW-1:0] out_red;
		logic [ChanW-1:0] out_green;
		logic [ChanW-1:0] out_blue;
		logic [ChanW-1:0] out_alpha;
	} result_t;

	// one lane's weighted contribution, zero when the pixel is skipped
	typedef struct packed {
		logic             keep;
		logic [ChanW-1:0] alpha;
		logic [ProdW-1:0] prod_r;
		logic [ProdW-1:0] prod_g;
		logic [ProdW-1:0] prod_b;
	} lane_t;

	typedef struct packed {
		logic [SumW-1:0]      sum_r;
		logic [SumW-1:0]      sum_g;
		logic [SumW-1:0]      sum_b;
		logic [AlphaSumW-1:0] sum_a;
		logic [KeptW-1:0]     kept;
	} merge_t;

endpackage

`default_nettype wire

/* src/awd_lane.sv */
// one pixel lane: alpha threshold test and the three color-times-alpha products
// depends on awd_pkg
`timescale 1ns / 1ps
`default_nettype none

module awd_lane
	import awd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [31:0]      pixel,
	input  wire logic [ChanW-1:0] threshold,
	output lane_t                 lane_s1
);

	logic [ChanW-1:0] red, green, blue, alpha;
	logic             keep;

	assign red   = pixel[31:24];
	assign green = pixel[23:16];
	assign blue  = pixel[15:8];
	assign alpha = pixel[7:0];
	assign keep  = (alpha >= threshold);

	// skipped pixels contribute nothing to the sums
	always_ff @(posedge clk) begin
		lane_s1.keep   <= keep;
		lane_s1.alpha  <= keep ? alpha : '0;
		lane_s1.prod_r <= keep ? ProdW'(red * alpha) : '0;
		lane_s1.prod_g <= keep ? ProdW'(green * alpha) : '0;
		lane_s1.prod_b <= keep ? ProdW'(blue * alpha) : '0;
	end

endmodule

`default_nettype wire

/* src/awd_merge.sv */
// merge stage: adds the four lane contributions and counts kept pixels
// depends on awd_pkg
`timescale 1ns / 1ps
`default_nettype none

module awd_merge
	import awd_pkg::*;
(
	input  wire logic  clk,
	input  wire lane_t lanes [Lanes],
	output merge_t     merge_s2
);

	merge_t sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < Lanes; i++) begin
			sum.sum_r = sum.sum_r + SumW'(lanes[i].prod_r);
			sum.sum_g = sum.sum_g + SumW'(lanes[i].prod_g);
			sum.sum_b = sum.sum_b + SumW'(lanes[i].prod_b);
			sum.sum_a = sum.sum_a + AlphaSumW'(lanes[i].alpha);
			sum.kept  = sum.kept + KeptW'(lanes[i].keep);
		end
	end

	always_ff @(posedge clk) begin
		merge_s2 <= sum;
	end

endmodule

`default_nettype wire

/* src/awd_div.sv */
// pipelined restoring divider: three color sums by the alpha sum, one
// quotient bit per stage, alpha average carried alongside; depends on awd_pkg
`timescale 1ns / 1ps
`default_nettype none

module awd_div
	import awd_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [Colors-1:0][SumW-1:0]  dividend,
	input  wire logic [AlphaSumW-1:0]         divisor,
	input  wire logic [ChanW-1:0]             tag_in,
	output logic                              out_valid,
	output logic [Colors-1:0][ChanW-1:0]      quotient,
	output logic [ChanW-1:0]                  tag_out
);

	logic                         vld_s [0:DivStages];
	logic [Colors-1:0][SumW-1:0]  rem_s [0:DivStages];
	logic [Colors-1:0][ChanW-1:0] quo_s [0:DivStages];
	logic [AlphaSumW-1:0]         dvs_s [0:DivStages];
	logic [ChanW-1:0]             tag_s [0:DivStages];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = dividend;
	assign quo_s[0] = '0;
	assign dvs_s[0] = divisor;
	assign tag_s[0] = tag_in;

	// the weighted mean never exceeds 255, so the dividend stays below
	// divisor << 8 and eight steps give the whole quotient
	for (genvar i = 0; i < DivStages; i++) begin : g_stage
		localparam int Shift = DivStages - 1 - i;

		logic [Colors-1:0][SumW:0] trial;
		logic [Colors-1:0]         ge;

		always_comb begin
			for (int c = 0; c < Colors; c++) begin
				trial[c] = {1'b0, rem_s[i][c]}
					- ({{(SumW + 1 - AlphaSumW){1'b0}}, dvs_s[i]} << Shift);
				ge[c] = ~trial[c][SumW];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < Colors; c++) begin
				rem_s[i+1][c] <= ge[c] ? trial[c][SumW-1:0] : rem_s[i][c];
				quo_s[i+1][c] <= {quo_s[i][c][ChanW-2:0], ge[c]};
			end
			dvs_s[i+1] <= dvs_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	// zero alpha sum only when nothing was kept or all kept alphas are zero
	assign out_valid = vld_s[DivStages];
	assign quotient  = (dvs_s[DivStages] == '0) ? '0 : quo_s[DivStages];
	assign tag_out   = tag_s[DivStages];

endmodule

`default_nettype wire

/* src/alpha_weighted_2x2_downsample.sv */
// top level of the alpha weighted 2x2 mipmap downsampler
// depends on awd_pkg, awd_lane, awd_merge, awd_div
`timescale 1ns / 1ps
`default_nettype none

// Takes one 2x2 block of RGBA8888 pixels per request and returns one pixel of
// the next mipmap level. A request is taken on every clock edge where start is
// high and busy is low; busy is high only in the first cycle after reset, so
// one request per cycle is sustained. Each result appears on result for exactly
// one cycle with done high. A request passes through the registered per-pixel
// lanes (threshold test and color-times-alpha multiplies), then the registered
// merge adder, then the pipelined divider that produces one quotient bit per
// stage. The receiver cannot stall the output, so it must take every done cycle.
// Results come out in request order. The alpha threshold is written through
// cfg_valid/cfg_data (cfg_ready is always high) and must only be changed while
// no request is in flight.
module alpha_weighted_2x2_downsample
	import awd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire pixel_block_t     pixels,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [ChanW-1:0] cfg_data
);

	logic                 busy_q;
	logic [ChanW-1:0]     thresh_q;
	logic                 accept;
	logic                 vld_s1, vld_s2;
	logic [31:0]          pix [Lanes];
	lane_t                lanes_s1 [Lanes];
	merge_t               merge_s2;
	logic [ChanW-1:0]     alpha_avg;
	logic [2*AlphaSumW-1:0] third;
	logic [Colors-1:0][SumW-1:0]  dividend;
	logic [Colors-1:0][ChanW-1:0] quotient;
	logic [ChanW-1:0]     alpha_out;

	// no back pressure anywhere, so only reset holds requests off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// valid flags for lane and merge stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	assign pix[0] = pixels.pixel_top_left;
	assign pix[1] = pixels.pixel_top_right;
	assign pix[2] = pixels.pixel_bottom_left;
	assign pix[3] = pixels.pixel_bottom_right;

	// one lane per source pixel
	for (genvar i = 0; i < Lanes; i++) begin : g_lane
		awd_lane u_lane (
			.clk       (clk),
			.pixel     (pix[i]),
			.threshold (thresh_q),
			.lane_s1   (lanes_s1[i])
		);
	end

	awd_merge u_merge (
		.clk      (clk),
		.lanes    (lanes_s1),
		.merge_s2 (merge_s2)
	);

	// mean alpha: divide by the kept count 1..4, thirds by reciprocal multiply
	assign third = {{AlphaSumW{1'b0}}, merge_s2.sum_a} * {{AlphaSumW{1'b0}}, Recip3};

	always_comb begin
		case (merge_s2.kept)
			3'd1:    alpha_avg = merge_s2.sum_a[ChanW-1:0];
			3'd2:    alpha_avg = merge_s2.sum_a[ChanW:1];
			3'd3:    alpha_avg = third[Recip3Shift+ChanW-1:Recip3Shift];
			3'd4:    alpha_avg = merge_s2.sum_a[ChanW+1:2];
			default: alpha_avg = '0;  // nothing kept
		endcase
	end

	assign dividend[0] = merge_s2.sum_r;
	assign dividend[1] = merge_s2.sum_g;
	assign dividend[2] = merge_s2.sum_b;

	// weighted color means; mean alpha rides along to stay aligned
	awd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.dividend  (dividend),
		.divisor   (merge_s2.sum_a),
		.tag_in    (alpha_avg),
		.out_valid (done),
		.quotient  (quotient),
		.tag_out   (alpha_out)
	);

	assign result.out_red   = quotient[0];
	assign result.out_green = quotient[1];
	assign result.out_blue  = quotient[2];
	assign result.out_alpha = alpha_out;

	// every accepted request comes back as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##10 done)
		else $error("request did not produce a result after ten cycles");

	// no result without a matching request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 10))
		else $error("result without a request");

	// a kept set averages at or above the threshold
	a_alpha_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.out_alpha != '0) |-> result.out_alpha >= thresh_q)
		else $error("mean alpha below threshold");

endmodule

`default_nettype wire

/* tb/awd_result_checker.sv */
// checker for the alpha weighted 2x2 downsampler: predicts and compares results
// depends on awd_pkg for the request and result structs and the threshold reset
`timescale 1ns / 1ps

module awd_result_checker
	import awd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  pixel_block_t          pixels,
	input  wire logic             done,
	input  result_t               result,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [ChanW-1:0] cfg_data,
	output int                    mismatch_count,
	output int                    outstanding
);

	logic [ChanW-1:0] threshold;
	result_t          expected_pixels[$];
	result_t          want;

	// alpha weighted mean of the kept pixels of one block
	function automatic result_t downsample_block(pixel_block_t blk, logic [ChanW-1:0] thr);
		logic [Lanes-1:0][31:0] px;
		logic [ChanW-1:0]       a;
		logic [SumW-1:0]        sum_r;
		logic [SumW-1:0]        sum_g;
		logic [SumW-1:0]        sum_b;
		logic [AlphaSumW-1:0]   sum_a;
		logic [KeptW-1:0]       kept;
		result_t                res;
		px    = blk;
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		sum_a = '0;
		kept  = '0;
		res   = '0;
		for (int i = 0; i < Lanes; i++) begin
			a = px[i][7:0];
			if (a >= thr) begin
				sum_r += SumW'(px[i][31:24]) * SumW'(a);
				sum_g += SumW'(px[i][23:16]) * SumW'(a);
				sum_b += SumW'(px[i][15:8]) * SumW'(a);
				sum_a += AlphaSumW'(a);
				kept  += 1'b1;
			end
		end
		// zero alpha sum only happens with a zero threshold
		if (kept != 0) begin
			if (sum_a != 0) begin
				res.out_red   = ChanW'(sum_r / sum_a);
				res.out_green = ChanW'(sum_g / sum_a);
				res.out_blue  = ChanW'(sum_b / sum_a);
			end
			res.out_alpha = ChanW'(sum_a / kept);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold <= ThreshReset;
			expected_pixels.delete();
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			// requests in flight use the threshold from before a write
			if (start && !busy)
				expected_pixels.push_back(downsample_block(pixels, threshold));
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t ns: result with no pending request, actual r=%0d g=%0d b=%0d a=%0d",
						$time, result.out_red, result.out_green, result.out_blue,
						result.out_alpha);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (result !== want) begin
						$display("%0t ns: mismatch, expected r=%0d g=%0d b=%0d a=%0d, actual r=%0d g=%0d b=%0d a=%0d",
							$time, want.out_red, want.out_green, want.out_blue,
							want.out_alpha, result.out_red, result.out_green,
							result.out_blue, result.out_alpha);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				threshold <= cfg_data;
			outstanding <= expected_pixels.size();
		end
	end

endmodule

/* tb/alpha_weighted_2x2_downsample_tb.sv */
// top of the testbench for the alpha weighted 2x2 downsampler: stimulus and verdict
// depends on awd_pkg, alpha_weighted_2x2_downsample and awd_result_checker
`timescale 1ns / 1ps

module alpha_weighted_2x2_downsample_tb;
	import awd_pkg::*;

	// cycles to let pass after the last result before touching the threshold
	localparam int DrainCycles   = 16;
	// cycles with no request, result or register write before giving up
	localparam int WatchdogLimit = 1000;
	localparam int PhaseItems    = 180;
	localparam int Phases        = 8;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	pixel_block_t     pixels    = '0;
	logic             cfg_valid = 1'b0;
	logic [ChanW-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	result_t          result;
	logic             cfg_ready;
	int               mismatch_count;
	int               outstanding;
	int               idle_cycles = 0;

	// threshold as last written, used to aim alphas at the boundary
	logic [ChanW-1:0] cur_thresh = ThreshReset;

	always #5 clk = ~clk;

	alpha_weighted_2x2_downsample i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixels    (pixels),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	awd_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.pixels         (pixels),
		.done           (done),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// watchdog: any accepted request, result or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("%0t ns: watchdog expired", $time);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// present one request at a falling edge and hold it until taken;
	// with gap zero start stays high and the next request follows directly
	task automatic send_block(input pixel_block_t blk, input int gap);
		start  <= 1'b1;
		pixels <= blk;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// stop requesting and wait until every result is back and the pipe is empty
	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// threshold write, only ever issued after a drain
	task automatic write_threshold(input logic [ChanW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid  <= 1'b0;
		cur_thresh = value;
	endtask

	// mostly back to back, some short pauses, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// alpha clustered on the threshold boundary, plus the extremes
	function automatic logic [7:0] pick_alpha(input logic [ChanW-1:0] thr);
		int v;
		case ($urandom_range(0, 9))
			0: begin
				v = int'(thr);
			end
			1: begin
				v = int'(thr) - 1;
			end
			2: begin
				v = int'(thr) + 1;
			end
			3: begin
				v = 0;
			end
			4: begin
				v = 255;
			end
			default: begin
				v = $urandom_range(0, 255);
			end
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_color();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hff;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_pixel(input logic [ChanW-1:0] thr);
		return {pick_color(), pick_color(), pick_color(), pick_alpha(thr)};
	endfunction

	initial begin
		logic [ChanW-1:0] phase_thresh[Phases];
		pixel_block_t     blk;
		bit               no_idle;
		int               gap;

		// boundary thresholds and the reset value first, then random ones and 128
		phase_thresh = '{8'd1, 8'd255, 8'd0, 8'd100, 8'($urandom_range(1, 255)),
			8'($urandom_range(2, 254)), 8'd128, 8'($urandom_range(0, 255))};
		no_idle = 1'b0;

		// reset held from time zero, released on a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed requests at the reset threshold of 100
		// nothing kept at all
		send_block('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 0);
		// every field at its maximum
		send_block('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0);
		// alpha exactly on the threshold is kept
		send_block('{32'hffff_ff64, 32'hffff_ff64, 32'hffff_ff64, 32'hffff_ff64}, 1);
		// alpha one below the threshold is skipped
		send_block('{32'hffff_ff63, 32'hffff_ff63, 32'hffff_ff63, 32'hffff_ff63}, 0);
		// single kept pixel, distinct per-channel values show byte order
		send_block('{32'h1234_56ff, 32'hffff_ff63, 32'hffff_ff00, 32'hffff_ff10}, 0);
		// two kept pixels
		send_block('{32'hff00_00c8, 32'h00ff_0064, 32'h0000_ff63, 32'hffff_ff00}, 2);
		// three kept pixels, divide by three
		send_block('{32'hff00_80ff, 32'h80ff_00c8, 32'h0080_ff96, 32'hffff_ff32}, 0);
		// four kept, unequal weights
		send_block('{32'hff00_0065, 32'h00ff_00ff, 32'h0000_ff80, 32'h8080_80c0}, 0);
		// kept pixels with black color
		send_block('{32'h0000_00ff, 32'h0000_00ff, 32'hffff_ff63, 32'h0000_0064}, 1);
		// top right, bottom left and bottom right alone in turn
		send_block('{32'haa55_aa63, 32'h55aa_55ff, 32'haa55_aa00, 32'h55aa_5563}, 0);
		send_block('{32'haa55_aa63, 32'h55aa_5500, 32'haa55_aaff, 32'h55aa_5563}, 0);
		send_block('{32'haa55_aa00, 32'h55aa_5563, 32'haa55_aa63, 32'h55aa_55ff}, 0);
		drain();

		// threshold at its low end: only zero alpha is skipped
		write_threshold(8'd1);
		send_block('{32'hffff_ff00, 32'hffff_ff01, 32'h0000_0000, 32'h8080_8001}, 0);
		send_block('{32'hffff_ff00, 32'hffff_ff00, 32'hffff_ff00, 32'hffff_ff00}, 0);
		drain();

		// threshold at its high end: only full alpha is kept
		write_threshold(8'd255);
		send_block('{32'hffff_fffe, 32'h1020_30ff, 32'hffff_fffe, 32'h4050_60ff}, 0);
		send_block('{32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffe}, 0);
		drain();

		// zero threshold keeps everything, so the alpha sum can be zero
		write_threshold(8'd0);
		send_block('{32'hffff_ff00, 32'hffff_ff00, 32'hffff_ff00, 32'hffff_ff00}, 0);
		send_block('{32'hffff_ff00, 32'h0000_0000, 32'h8040_2000, 32'hffff_ff07}, 0);
		send_block('{32'h1122_3300, 32'h4455_6601, 32'h7788_9900, 32'haabb_cc00}, 0);
		drain();

		// random phases, one threshold each
		for (int p = 0; p < Phases; p++) begin
			write_threshold(phase_thresh[p]);
			for (int i = 0; i < PhaseItems; i++) begin
				// occasional stretches with back to back requests only
				if (i % 32 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				blk.pixel_top_left     = pick_pixel(cur_thresh);
				blk.pixel_top_right    = pick_pixel(cur_thresh);
				blk.pixel_bottom_left  = pick_pixel(cur_thresh);
				blk.pixel_bottom_right = pick_pixel(cur_thresh);
				gap = no_idle ? 0 : pick_gap();
				send_block(blk, gap);
			end
			drain();
		end

		// leave the threshold back at its reset value
		write_threshold(ThreshReset);
		repeat (DrainCycles) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/awd_pkg.sv
src/awd_lane.sv
src/awd_merge.sv
src/awd_div.sv
src/alpha_weighted_2x2_downsample.sv
tb/awd_result_checker.sv
tb/alpha_weighted_2x2_downsample_tb.sv
